/* design/hce_pkg.sv */
// ----------------------------------------------------------------------------
// hce_pkg
// Opcodes, status codes and fixed field widths of the Huffman code engine.
// ----------------------------------------------------------------------------
package hce_pkg;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_COUNT  = 3'd1;
	localparam logic [2:0] OP_BUILD  = 3'd2;
	localparam logic [2:0] OP_ENCODE = 3'd3;
	localparam logic [2:0] OP_DECODE = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SAT      = 3'd1;
	localparam logic [2:0] ST_NOT_BUILT = 3'd2;
	localparam logic [2:0] ST_ABSENT   = 3'd3;
	localparam logic [2:0] ST_NO_DEC   = 3'd4;

	localparam int CODE_LEN_W = 6;
	localparam int CODE_VAL_W = 32;

endpackage

/* design/huffman_code_engine_core.sv */
// ----------------------------------------------------------------------------
// huffman_code_engine_core
// Byte-alphabet Huffman engine: histogram, tree build, encode and decode.
// ----------------------------------------------------------------------------
// Input beats carry an opcode in s_tuser and a symbol / code bit in s_tdata.
// Every input beat yields exactly one output beat on the m_ side with a
// status, a decoded symbol or a code and its length.
// Clear, count, encode and decode run back to back unless the output stalls:
// a beat is read from RAM in its accept cycle and answered from the output
// register behind the front stage. Counts to one symbol in successive cycles
// are forwarded around the histogram RAM; decode steps forward the next tree
// position into the node RAM read address.
// Build holds the input side while it loads the leaf weights, merges until
// one root is left, writes the code paths and fills the code table. Each merge
// scans the node RAM once, one entry per cycle, for the two lightest nodes.
// Reset clears the histogram, the code table and the tree state through
// per-entry valid flops; node and path RAMs need no clearing.
// When m_tready is low the output register holds its beat and the input side
// stalls as soon as the stage behind it is also full.
// ----------------------------------------------------------------------------
module huffman_code_engine_core #(
	parameter int ALPHABET_SIZE = 256,
	parameter int COUNT_BITS    = 20,
	parameter int MAX_CODE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] symbol_in, [8] code_bit
	input  logic [2:0]  s_tuser,  // [2:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // [7:0] symbol_out, [39:8] code_value, [45:40] code_length
	output logic [3:0]  m_tuser   // [2:0] status, [3] symbol_valid
);

	import hce_pkg::*;

	localparam int AW    = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int NW    = AW + 1;
	localparam int NODES = 2 * ALPHABET_SIZE;
	localparam int WW    = COUNT_BITS + AW;
	localparam int LW    = NW;
	localparam int NDW   = WW + 2 * NW;
	localparam int PW    = LW + MAX_CODE_BITS;
	localparam int CW    = CODE_LEN_W + MAX_CODE_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [NW-1:0] A_N = NW'(ALPHABET_SIZE);

	localparam logic [3:0] B_IDLE  = 4'd0;
	localparam logic [3:0] B_INIT  = 4'd1;
	localparam logic [3:0] B_SCAN  = 4'd2;
	localparam logic [3:0] B_MERGE = 4'd3;
	localparam logic [3:0] B_KILLA = 4'd4;
	localparam logic [3:0] B_KILLB = 4'd5;
	localparam logic [3:0] B_ROOT  = 4'd6;
	localparam logic [3:0] B_PRD   = 4'd7;
	localparam logic [3:0] B_PWL   = 4'd8;
	localparam logic [3:0] B_PWR   = 4'd9;
	localparam logic [3:0] B_LEAF  = 4'd10;
	localparam logic [3:0] B_FIN   = 4'd11;

	// RAM ports
	logic                  hist_we, hist_re;
	logic [AW-1:0]         hist_wa, hist_ra;
	logic [COUNT_BITS-1:0] hist_wd, hist_rd;
	logic                  node_we, node_re;
	logic [NW-1:0]         node_wa, node_ra;
	logic [NDW-1:0]        node_wd, node_rd;
	logic                  live_we, live_re, live_wd, live_rd;
	logic [NW-1:0]         live_wa, live_ra;
	logic                  path_we, path_re;
	logic [NW-1:0]         path_wa, path_ra;
	logic [PW-1:0]         path_wd, path_rd;
	logic                  code_we, code_re;
	logic [AW-1:0]         code_wa, code_ra;
	logic [CW-1:0]         code_wd, code_rd;

	// front stage
	logic                  s1_valid_q, s1_bit_q, s1_inr_q;
	logic [2:0]            s1_op_q;
	logic [7:0]            s1_sym_q;
	logic                  acc, s1_adv, s1_done;
	logic [AW-1:0]         sym_idx, s1_idx;

	// engine state
	logic [ALPHABET_SIZE-1:0] hist_vld_q, present_q;
	logic                  built_q, ovf_q;
	logic [NW-1:0]         root_q, pos_q;
	logic                  fwd_v_q;
	logic [AW-1:0]         fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_data_q;

	// build sequencer
	logic [3:0]            bstate_q;
	logic [NW-1:0]         b_cnt_q, b_pidx_q, b_live_q, b_leaf_q, b_next_q, b_root_q;
	logic                  b_pend_q, b_drop_q, b_built_q;
	logic [2:0]            b_status_q;
	logic                  f_have_q, s_have_q;
	logic [NW-1:0]         f_idx_q, s_idx_q;
	logic [WW-1:0]         f_w_q, s_w_q;
	logic                  b_issue;
	logic [COUNT_BITS-1:0] h_val;
	logic [WW-1:0]         nd_w;
	logic [NW-1:0]         nd_l, nd_r;
	logic [LW-1:0]         p_len;
	logic [MAX_CODE_BITS-1:0] p_code;

	// result of the front stage
	logic [2:0]            r_status;
	logic                  r_valid;
	logic [7:0]            r_sym;
	logic [CODE_VAL_W-1:0] r_cval;
	logic [CODE_LEN_W-1:0] r_clen;
	logic [NW-1:0]         nx_pos, nx_root, dec_addr, nxt;
	logic                  nx_built;
	logic [COUNT_BITS-1:0] hist_cur;

	// output register
	logic                  m_valid_q;
	logic [2:0]            m_status_q;
	logic                  m_symv_q;
	logic [7:0]            m_sym_q;
	logic [CODE_VAL_W-1:0] m_cval_q;
	logic [CODE_LEN_W-1:0] m_clen_q;

	hce_ram #(.WIDTH(COUNT_BITS), .DEPTH(ALPHABET_SIZE)) u_hist (
		.clk, .we(hist_we), .waddr(hist_wa), .wdata(hist_wd),
		.re(hist_re), .raddr(hist_ra), .rdata(hist_rd));
	hce_ram #(.WIDTH(NDW), .DEPTH(NODES)) u_node (
		.clk, .we(node_we), .waddr(node_wa), .wdata(node_wd),
		.re(node_re), .raddr(node_ra), .rdata(node_rd));
	hce_ram #(.WIDTH(1), .DEPTH(NODES)) u_live (
		.clk, .we(live_we), .waddr(live_wa), .wdata(live_wd),
		.re(live_re), .raddr(live_ra), .rdata(live_rd));
	hce_ram #(.WIDTH(PW), .DEPTH(NODES)) u_path (
		.clk, .we(path_we), .waddr(path_wa), .wdata(path_wd),
		.re(path_re), .raddr(path_ra), .rdata(path_rd));
	hce_ram #(.WIDTH(CW), .DEPTH(ALPHABET_SIZE)) u_code (
		.clk, .we(code_we), .waddr(code_wa), .wdata(code_wd),
		.re(code_re), .raddr(code_ra), .rdata(code_rd));

	assign sym_idx = s_tdata[AW-1:0];
	assign s1_idx  = s1_sym_q[AW-1:0];
	assign nd_w    = node_rd[NDW-1:2*NW];
	assign nd_l    = node_rd[2*NW-1:NW];
	assign nd_r    = node_rd[NW-1:0];
	assign p_len   = path_rd[PW-1:MAX_CODE_BITS];
	assign p_code  = path_rd[MAX_CODE_BITS-1:0];
	assign h_val   = hist_vld_q[b_pidx_q[AW-1:0]] ? hist_rd : '0;

	assign s1_done  = (s1_op_q != OP_BUILD) || (bstate_q == B_FIN);
	assign s1_adv   = s1_valid_q && s1_done && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_adv;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		case (bstate_q)
			B_INIT, B_LEAF: b_issue = (b_cnt_q < A_N);
			B_SCAN:         b_issue = (b_cnt_q < b_next_q);
			default:        b_issue = 1'b0;
		endcase
	end

	// ---------------- front stage result ----------------
	assign hist_cur = (fwd_v_q && fwd_addr_q == s1_idx) ? fwd_data_q
		: (hist_vld_q[s1_idx] ? hist_rd : '0);
	assign nxt = s1_bit_q ? nd_r : nd_l;

	always_comb begin
		r_status = ST_OK;
		r_valid  = 1'b0;
		r_sym    = '0;
		r_cval   = '0;
		r_clen   = '0;
		nx_pos   = pos_q;
		nx_root  = root_q;
		nx_built = built_q;
		hist_we  = 1'b0;
		hist_wd  = hist_cur + COUNT_BITS'(1);
		case (s1_op_q)
			OP_CLEAR: begin
				nx_pos   = '0;
				nx_root  = '0;
				nx_built = 1'b0;
			end
			OP_COUNT: begin
				if (!s1_inr_q)
					r_status = ST_ABSENT;
				else if (hist_cur == COUNT_MAX)
					r_status = ST_SAT;
				else
					hist_we = s1_valid_q;
			end
			OP_BUILD: begin
				r_status = b_status_q;
				nx_pos   = b_root_q;
				nx_root  = b_root_q;
				nx_built = b_built_q;
			end
			OP_ENCODE: begin
				if (!built_q)
					r_status = ST_NOT_BUILT;
				else if (!s1_inr_q || !present_q[s1_idx])
					r_status = ST_ABSENT;
				else begin
					r_cval = CODE_VAL_W'(code_rd[MAX_CODE_BITS-1:0]);
					r_clen = code_rd[CW-1:MAX_CODE_BITS];
				end
			end
			OP_DECODE: begin
				if (!built_q)
					r_status = ST_NOT_BUILT;
				else if (root_q < A_N)
					r_status = ST_NO_DEC;
				else if (nxt < A_N) begin
					r_valid = 1'b1;
					r_sym   = 8'(nxt);
					nx_pos  = root_q;
				end else
					nx_pos = nxt;
			end
			default: ;
		endcase
	end

	// a decode right behind a decode reads the position the one ahead moves to
	assign dec_addr = s1_valid_q ? nx_pos : pos_q;
	assign hist_wa  = s1_idx;

	// ---------------- RAM access ----------------
	always_comb begin
		hist_re = acc || (b_issue && bstate_q != B_SCAN);
		hist_ra = acc ? sym_idx : b_cnt_q[AW-1:0];
		node_re = acc || (b_issue && bstate_q == B_SCAN) || bstate_q == B_PRD;
		node_ra = acc ? dec_addr : b_cnt_q;
		live_re = b_issue && bstate_q == B_SCAN;
		live_ra = b_cnt_q;
		path_re = bstate_q == B_PRD || (b_issue && bstate_q == B_LEAF);
		path_ra = b_cnt_q;
		code_re = acc;
		code_ra = sym_idx;
	end

	always_comb begin
		node_we = 1'b0;
		node_wa = b_pidx_q;
		node_wd = {WW'(h_val), {(2*NW){1'b0}}};
		live_we = 1'b0;
		live_wa = b_pidx_q;
		live_wd = (h_val != '0);
		path_we = 1'b0;
		path_wa = b_root_q;
		path_wd = '0;
		code_we = 1'b0;
		code_wa = b_pidx_q[AW-1:0];
		code_wd = {CODE_LEN_W'(p_len), p_code};
		case (bstate_q)
			B_INIT: begin
				node_we = b_pend_q;
				live_we = b_pend_q;
			end
			B_MERGE: begin
				node_we = 1'b1;
				node_wa = b_next_q;
				node_wd = {f_w_q + s_w_q, f_idx_q, s_idx_q};
				live_we = 1'b1;
				live_wa = b_next_q;
				live_wd = 1'b1;
			end
			B_KILLA: begin
				live_we = 1'b1;
				live_wa = f_idx_q;
				live_wd = 1'b0;
			end
			B_KILLB: begin
				live_we = 1'b1;
				live_wa = s_idx_q;
				live_wd = 1'b0;
			end
			B_ROOT: path_we = 1'b1;
			B_PWL: begin
				path_we = 1'b1;
				path_wa = nd_l;
				path_wd = {p_len + LW'(1), p_code << 1};
			end
			B_PWR: begin
				path_we = 1'b1;
				path_wa = nd_r;
				path_wd = {p_len + LW'(1), (p_code << 1) | MAX_CODE_BITS'(1)};
			end
			B_LEAF: code_we = b_pend_q && (h_val != '0)
				&& (32'(p_len) <= MAX_CODE_BITS);
			default: ;
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
			hist_vld_q <= '0;
			present_q  <= '0;
			built_q    <= 1'b0;
			ovf_q      <= 1'b0;
			root_q     <= '0;
			pos_q      <= '0;
			fwd_v_q    <= 1'b0;
			bstate_q   <= B_IDLE;
			b_cnt_q    <= '0;
			b_pend_q   <= 1'b0;
			b_live_q   <= '0;
			b_next_q   <= '0;
			b_root_q   <= '0;
			b_drop_q   <= 1'b0;
			b_built_q  <= 1'b0;
			b_status_q <= ST_OK;
			f_have_q   <= 1'b0;
			s_have_q   <= 1'b0;
		end else begin
			if (acc)
				s1_valid_q <= 1'b1;
			else if (s1_adv)
				s1_valid_q <= 1'b0;

			if (s1_adv)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;

			if (s1_adv) begin
				pos_q   <= nx_pos;
				root_q  <= nx_root;
				built_q <= nx_built;
				fwd_v_q <= hist_we;
				if (hist_we)
					hist_vld_q[s1_idx] <= 1'b1;
				if (s1_op_q == OP_CLEAR) begin
					hist_vld_q <= '0;
					present_q  <= '0;
					ovf_q      <= 1'b0;
					fwd_v_q    <= 1'b0;
				end
				if (s1_op_q == OP_COUNT && s1_inr_q && hist_cur == COUNT_MAX)
					ovf_q <= 1'b1;
			end

			if (code_we)
				present_q[b_pidx_q[AW-1:0]] <= 1'b1;

			case (bstate_q)
				// a build may follow a build in the very cycle the first one retires
				B_IDLE, B_FIN: begin
					if (acc && s_tuser == OP_BUILD) begin
						bstate_q  <= B_INIT;
						b_cnt_q   <= '0;
						b_pend_q  <= 1'b0;
						b_live_q  <= '0;
						b_drop_q  <= 1'b0;
						present_q <= '0;
					end else if (s1_adv)
						bstate_q <= B_IDLE;
				end
				B_INIT: begin
					b_pend_q <= b_issue;
					if (b_issue)
						b_cnt_q <= b_cnt_q + NW'(1);
					if (b_pend_q && h_val != '0) begin
						b_live_q <= b_live_q + NW'(1);
						b_leaf_q <= b_pidx_q;
					end
					if (!b_issue && !b_pend_q) begin
						if (b_live_q == '0) begin
							b_status_q <= ST_NOT_BUILT;
							b_built_q  <= 1'b0;
							b_root_q   <= '0;
							bstate_q   <= B_FIN;
						end else if (b_live_q == NW'(1)) begin
							b_root_q <= b_leaf_q;
							b_next_q <= A_N;
							bstate_q <= B_ROOT;
						end else begin
							b_next_q <= A_N;
							b_cnt_q  <= '0;
							f_have_q <= 1'b0;
							s_have_q <= 1'b0;
							bstate_q <= B_SCAN;
						end
					end
				end
				B_SCAN: begin
					b_pend_q <= b_issue;
					if (b_issue)
						b_cnt_q <= b_cnt_q + NW'(1);
					// strict compares keep the lower index on equal weights
					if (b_pend_q && live_rd) begin
						if (!f_have_q || nd_w < f_w_q) begin
							s_have_q <= f_have_q;
							s_idx_q  <= f_idx_q;
							s_w_q    <= f_w_q;
							f_have_q <= 1'b1;
							f_idx_q  <= b_pidx_q;
							f_w_q    <= nd_w;
						end else if (!s_have_q || nd_w < s_w_q) begin
							s_have_q <= 1'b1;
							s_idx_q  <= b_pidx_q;
							s_w_q    <= nd_w;
						end
					end
					if (!b_issue && !b_pend_q)
						bstate_q <= B_MERGE;
				end
				B_MERGE: bstate_q <= B_KILLA;
				B_KILLA: bstate_q <= B_KILLB;
				B_KILLB: begin
					b_next_q <= b_next_q + NW'(1);
					b_live_q <= b_live_q - NW'(1);
					if (b_live_q == NW'(2)) begin
						b_root_q <= b_next_q;
						bstate_q <= B_ROOT;
					end else begin
						b_cnt_q  <= '0;
						b_pend_q <= 1'b0;
						f_have_q <= 1'b0;
						s_have_q <= 1'b0;
						bstate_q <= B_SCAN;
					end
				end
				B_ROOT: begin
					b_pend_q <= 1'b0;
					if (b_next_q == A_N) begin
						b_cnt_q  <= '0;
						bstate_q <= B_LEAF;
					end else begin
						b_cnt_q  <= b_next_q - NW'(1);
						bstate_q <= B_PRD;
					end
				end
				B_PRD: bstate_q <= B_PWL;
				B_PWL: bstate_q <= B_PWR;
				B_PWR: begin
					if (b_cnt_q == A_N) begin
						b_cnt_q  <= '0;
						bstate_q <= B_LEAF;
					end else begin
						b_cnt_q  <= b_cnt_q - NW'(1);
						bstate_q <= B_PRD;
					end
				end
				B_LEAF: begin
					b_pend_q <= b_issue;
					if (b_issue)
						b_cnt_q <= b_cnt_q + NW'(1);
					if (b_pend_q && h_val != '0 && 32'(p_len) > MAX_CODE_BITS)
						b_drop_q <= 1'b1;
					if (!b_issue && !b_pend_q) begin
						b_status_q <= b_drop_q ? ST_ABSENT : ST_OK;
						b_built_q  <= 1'b1;
						bstate_q   <= B_FIN;
					end
				end
				default: bstate_q <= B_IDLE;
			endcase
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (acc) begin
			s1_op_q  <= s_tuser;
			s1_sym_q <= s_tdata[7:0];
			s1_bit_q <= s_tdata[8];
			s1_inr_q <= (9'(s_tdata[7:0]) < 9'(ALPHABET_SIZE));
		end
		b_pidx_q <= b_cnt_q;
		if (s1_adv) begin
			m_status_q <= r_status;
			m_symv_q   <= r_valid;
			m_sym_q    <= r_sym;
			m_cval_q   <= r_cval;
			m_clen_q   <= r_clen;
			if (hist_we) begin
				fwd_addr_q <= s1_idx;
				fwd_data_q <= hist_wd;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, m_clen_q, m_cval_q, m_sym_q};
	assign m_tuser  = {m_symv_q, m_status_q};

endmodule

/* design/hce_ram.sv */
// ----------------------------------------------------------------------------
// hce_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

/* test/huffman_code_engine_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_code_engine_core_tb
// Streams opcode beats into the Huffman engine and checks every answer beat
// against a behavioral model of histogram, tree build, encode and decode.
// ----------------------------------------------------------------------------
module huffman_code_engine_core_tb;

	import hce_pkg::*;

	localparam int NSYM      = 256;
	localparam int NSLOT     = 512;
	localparam int CNT_MAX   = (1 << 20) - 1;
	localparam int MAX_BITS  = 32;
	localparam longint CYCLE_LIMIT = 64'd30000000;

	typedef struct packed {
		logic [2:0]  status;
		logic        sym_valid;
		logic [7:0]  sym_out;
		logic [31:0] code_value;
		logic [5:0]  code_length;
	} answer_t;

	// Behavioral engine plus a queue of pending answers.
	class huff_scoreboard;
		int unsigned hist[NSYM];
		longint      wt[NSLOT];
		int          lft[NSLOT];
		int          rgt[NSLOT];
		bit          live[NSLOT];
		bit          present[NSYM];
		logic [31:0] cbits[NSYM];
		int          clen[NSYM];
		longint      pcode[NSLOT];
		int          plen[NSLOT];
		int          root;
		int          pos;
		bit          built;
		answer_t     pending[$];
		int          errors;

		function void wipe_tree();
			foreach (present[i]) begin
				present[i] = 0;
				cbits[i] = '0;
				clen[i] = 0;
			end
			root = 0;
			pos = 0;
			built = 0;
		endfunction

		function void init();
			foreach (hist[i]) hist[i] = 0;
			wipe_tree();
			pending.delete();
			errors = 0;
		endfunction

		function int lightest(int lim, int skip);
			int best;
			best = -1;
			for (int i = 0; i < lim; i++) begin
				if (!live[i] || i == skip) continue;
				if (best < 0 || wt[i] < wt[best]) best = i;
			end
			return best;
		endfunction

		function logic [2:0] build();
			int n_live, nxt, a, b;
			bit dropped;
			n_live = 0;
			nxt = NSYM;
			dropped = 0;
			wipe_tree();
			foreach (live[i]) live[i] = 0;
			for (int i = 0; i < NSYM; i++)
				if (hist[i] != 0) begin
					live[i] = 1;
					wt[i] = hist[i];
					n_live++;
				end
			if (n_live == 0) return ST_NOT_BUILT;
			while (n_live > 1 && nxt < NSLOT) begin
				a = lightest(nxt, -1);
				b = lightest(nxt, a);
				lft[nxt] = a;
				rgt[nxt] = b;
				wt[nxt] = wt[a] + wt[b];
				live[a] = 0;
				live[b] = 0;
				live[nxt] = 1;
				nxt++;
				n_live--;
			end
			root = lightest(nxt, -1);
			pcode[root] = 0;
			plen[root] = 0;
			for (int k = nxt - 1; k >= NSYM; k--) begin
				pcode[lft[k]] = pcode[k] << 1;
				plen[lft[k]] = plen[k] + 1;
				pcode[rgt[k]] = (pcode[k] << 1) | 1;
				plen[rgt[k]] = plen[k] + 1;
			end
			for (int i = 0; i < NSYM; i++) begin
				if (hist[i] == 0) continue;
				if (plen[i] <= MAX_BITS) begin
					present[i] = 1;
					cbits[i] = pcode[i][31:0];
					clen[i] = plen[i];
				end else
					dropped = 1;
			end
			pos = root;
			built = 1;
			return dropped ? ST_ABSENT : ST_OK;
		endfunction

		function void note_input(logic [2:0] op, logic [7:0] sym, logic bit_in);
			answer_t r;
			int nx;
			r = '0;
			case (op)
				OP_CLEAR: begin
					foreach (hist[i]) hist[i] = 0;
					wipe_tree();
				end
				OP_COUNT: begin
					if (hist[sym] >= CNT_MAX) begin
						hist[sym] = CNT_MAX;
						r.status = ST_SAT;
					end else
						hist[sym]++;
				end
				OP_BUILD: r.status = build();
				OP_ENCODE: begin
					if (!built) r.status = ST_NOT_BUILT;
					else if (!present[sym]) r.status = ST_ABSENT;
					else begin
						r.code_value = cbits[sym];
						r.code_length = clen[sym];
					end
				end
				OP_DECODE: begin
					if (!built) r.status = ST_NOT_BUILT;
					else if (root < NSYM || pos < NSYM) r.status = ST_NO_DEC;
					else begin
						nx = bit_in ? rgt[pos] : lft[pos];
						if (nx < NSYM) begin
							r.sym_valid = 1;
							r.sym_out = nx[7:0];
							pos = root;
						end else
							pos = nx;
					end
				end
				default: ;
			endcase
			pending.push_back(r);
		endfunction

		function void check_answer(answer_t got);
			answer_t exp;
			if (pending.size() == 0) begin
				$error("answer beat with nothing expected");
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status) begin
				$error("status exp %0d got %0d", exp.status, got.status);
				errors++;
			end
			if (got.sym_valid !== exp.sym_valid) begin
				$error("symbol_valid exp %0d got %0d", exp.sym_valid, got.sym_valid);
				errors++;
			end
			if (got.sym_out !== exp.sym_out) begin
				$error("symbol_out exp %0d got %0d", exp.sym_out, got.sym_out);
				errors++;
			end
			if (got.code_value !== exp.code_value) begin
				$error("code_value exp %h got %h", exp.code_value, got.code_value);
				errors++;
			end
			if (got.code_length !== exp.code_length) begin
				$error("code_length exp %0d got %0d", exp.code_length, got.code_length);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;  // [7:0] symbol_in, [8] code_bit
	logic [2:0]  s_tuser;  // [2:0] opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;  // [7:0] symbol_out, [39:8] code_value, [45:40] code_length
	logic [3:0]  m_tuser;  // [2:0] status, [3] symbol_valid

	huff_scoreboard sb;
	longint cycles;
	int     hold_off;     // long receiver stall request, in cycles
	bit     fill_mode;    // sender keeps offering without gaps
	int     built_syms[$];

	huffman_code_engine_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		sb = new();
		sb.init();
		hold_off = 0;
		fill_mode = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= (arst_n === 1'b1) ? cycles + 1 : 0;
		if (cycles > CYCLE_LIMIT) begin
			$display("huffman_code_engine_core_tb: FAIL");
			$finish;
		end
	end

	// Receiver: own stall pattern, plus long hold-offs on request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				answer_t got;
				got.status = m_tuser[2:0];
				got.sym_valid = m_tuser[3];
				got.sym_out = m_tdata[7:0];
				got.code_value = m_tdata[39:8];
				got.code_length = m_tdata[45:40];
				sb.check_answer(got);
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				m_tready <= 1'b0;
			end else if (cycles[9:8] == 2'b11)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	int burst_left;
	int items;

	// One beat: hold valid until accepted; the next beat reuses the same edge.
	task automatic send_beat(logic [2:0] op, logic [7:0] sym, logic bit_in);
		if (!fill_mode && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		if (burst_left > 0) burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'd0, bit_in, sym};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(op, sym, bit_in);
		items++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic count_n(logic [7:0] sym, int n);
		repeat (n) send_beat(OP_COUNT, sym, 1'b0);
	endtask

	// Random decode walk: mostly bits that follow real codes.
	task automatic decode_run(int n);
		int s;
		for (int i = 0; i < n; i++) begin
			if (built_syms.size() != 0 && $urandom_range(0, 3) != 0) begin
				s = built_syms[$urandom_range(0, built_syms.size() - 1)];
				if (sb.clen[s] > 0)
					for (int b = sb.clen[s] - 1; b >= 0; b--)
						send_beat(OP_DECODE, 8'd0, sb.cbits[s][b]);
			end else
				send_beat(OP_DECODE, 8'($urandom()), 1'($urandom()));
		end
	endtask

	task automatic do_build();
		send_beat(OP_BUILD, 8'($urandom()), 1'($urandom()));
		built_syms.delete();
		for (int i = 0; i < NSYM; i++)
			if (sb.hist[i] != 0) built_syms.push_back(i);
	endtask

	int nsyms;

	initial begin
		burst_left = 0;
		items = 0;
		@(posedge arst_n);
		@(posedge clk);
		// directed: before build, empty build, single leaf, extremes
		send_beat(OP_DECODE, 8'd0, 1'b1);
		send_beat(OP_ENCODE, 8'd0, 1'b0);
		send_beat(OP_BUILD, 8'd0, 1'b0);
		send_beat(3'd5, 8'hFF, 1'b1);
		send_beat(3'd7, 8'h00, 1'b0);
		count_n(8'hFF, 3);
		do_build();
		send_beat(OP_ENCODE, 8'hFF, 1'b0);
		send_beat(OP_ENCODE, 8'h00, 1'b0);
		send_beat(OP_DECODE, 8'd0, 1'b0);
		count_n(8'h00, 1);
		count_n(8'h80, 2);
		count_n(8'h7F, 4);
		do_build();
		for (int s = 0; s < 4; s++)
			send_beat(OP_ENCODE, (s == 0) ? 8'h00 : (s == 1) ? 8'h80 : (s == 2) ? 8'h7F : 8'hFF,
				1'b0);
		decode_run(3);
		send_beat(OP_CLEAR, 8'hAA, 1'b1);
		send_beat(OP_ENCODE, 8'h00, 1'b0);
		// long hold-off on the receiver while the sender keeps pushing
		drain();
		hold_off = 200;
		fill_mode = 1;
		count_n(8'h55, 12);
		fill_mode = 0;
		drain();

		// random sessions: clear, count, build, encode/decode
		while (items < 1650) begin
			send_beat(OP_CLEAR, 8'($urandom()), 1'($urandom()));
			nsyms = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			for (int i = 0; i < nsyms; i++) begin
				// skewed counts make deep trees now and then
				count_n(8'($urandom()), ($urandom_range(0, 3) == 0) ? (1 << $urandom_range(0, 4))
					: $urandom_range(1, 3));
			end
			if ($urandom_range(0, 4) == 0) send_beat(OP_DECODE, 8'd0, 1'($urandom()));
			do_build();
			for (int i = 0; i < 30; i++) begin
				case ($urandom_range(0, 5))
					0, 1: send_beat(OP_ENCODE, ($urandom_range(0, 1) && built_syms.size() != 0) ?
						8'(built_syms[$urandom_range(0, built_syms.size() - 1)]) :
						8'($urandom()), 1'($urandom()));
					2, 3: decode_run(1);
					4: count_n(8'($urandom()), 1);
					default: send_beat(3'($urandom_range(5, 7)), 8'($urandom()), 1'($urandom()));
				endcase
			end
			if ($urandom_range(0, 9) == 0) drain();
		end

		send_beat(OP_CLEAR, 8'd0, 1'b0);
		// Fibonacci-like weights: the deepest tree for a given number of counts
		begin
			int fa, fb, ft;
			fa = 1;
			fb = 1;
			for (int s = 0; s < 36; s++) begin
				count_n(8'(s), fa);
				ft = fa + fb;
				fa = fb;
				fb = ft;
				if (fa > 100) break;
			end
		end
		do_build();
		send_beat(OP_ENCODE, 8'd0, 1'b0);
		send_beat(OP_ENCODE, 8'd1, 1'b0);
		decode_run(6);

		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("huffman_code_engine_core_tb: PASS");
		else
			$display("huffman_code_engine_core_tb: FAIL");
		$finish;
	end

endmodule
